FILE: hw/rtl/vpv_pkg.sv
// shared types and constants for the vertex projection pipeline
package vpv_pkg;

    localparam int FRAC_BITS = 16;
    // bits of the reciprocal dividend 2^(2*FRAC_BITS)
    localparam int DIV_BITS  = 2 * FRAC_BITS + 1;

    localparam logic signed [31:0] FIX_ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic {
        CMD_WRITE   = 1'b0,
        CMD_PROJECT = 1'b1
    } t_cmd;

    typedef enum logic {
        MAT_VIEW = 1'b0,
        MAT_PROJ = 1'b1
    } t_mat_sel;

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_BOTTOM = 2'd1,
        CFG_SPAN_X = 2'd2,
        CFG_SPAN_Y = 2'd3
    } t_cfg_idx;

    typedef logic [2:0][31:0]  t_vec3;
    typedef logic [15:0][31:0] t_mat;

    // per-beat control that travels with the data
    typedef struct packed {
        logic        vld;
        logic        vtx;
        logic        pwr;
        logic [3:0]  idx;
        logic [31:0] val;
        logic        bad;
    } t_side;

endpackage

FILE: hw/rtl/vpv_xform.sv
// one matrix transform with perspective divide, fully pipelined
module vpv_xform (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  vpv_pkg::t_side i_side,
    input  vpv_pkg::t_vec3 i_vec,
    input  vpv_pkg::t_mat  i_mat,
    output vpv_pkg::t_side o_side,
    output vpv_pkg::t_vec3 o_vec
);
    import vpv_pkg::*;

    t_side              r_a_side, r_b_side, r_c_side, r_n_side, r_m_side, r_f_side;
    logic signed [63:0] r_a_prod [4][3];
    logic [3:0][31:0]   r_a_tr, r_b_tr, r_c_o;
    logic [63:0]        r_b_sum [4];

    t_side               r_q_side [DIV_BITS+1];
    logic [31:0]         r_q_rem  [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_q_quo  [DIV_BITS+1];
    logic [31:0]         r_q_den  [DIV_BITS+1];
    logic                r_q_neg  [DIV_BITS+1];
    logic                r_q_one  [DIV_BITS+1];
    t_vec3               r_q_o    [DIV_BITS+1];

    logic [32:0]         n_trial [DIV_BITS];
    logic                n_ge    [DIV_BITS];
    logic [31:0]         n_rem   [DIV_BITS];
    logic [DIV_BITS-1:0] n_quo   [DIV_BITS];

    logic [31:0]        r_n_inv;
    logic               r_n_one, r_m_one;
    t_vec3              r_n_o, r_m_o, r_f_o;
    logic signed [63:0] r_m_prod [3];

    logic [31:0] w_c;
    t_side       n_q0_side;

    assign w_c = r_c_o[3];

    always_comb begin
        n_q0_side     = r_c_side;
        n_q0_side.bad = r_c_side.bad | (w_c == 32'd0);
    end

    // restoring divide, one quotient bit per stage; dividend has only its top bit set
    always_comb begin
        for (int k = 0; k < DIV_BITS; k++) begin
            n_trial[k] = {r_q_rem[k], (k == 0)};
            n_ge[k]    = n_trial[k] >= {1'b0, r_q_den[k]};
            n_rem[k]   = n_ge[k] ? 32'(n_trial[k] - {1'b0, r_q_den[k]}) : n_trial[k][31:0];
            n_quo[k]   = {r_q_quo[k][DIV_BITS-2:0], n_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
            r_c_side <= '0;
            r_n_side <= '0;
            r_m_side <= '0;
            r_f_side <= '0;
            for (int k = 0; k <= DIV_BITS; k++) begin
                r_q_side[k] <= '0;
            end
        end else if (i_en) begin
            r_a_side    <= i_side;
            r_b_side    <= r_a_side;
            r_c_side    <= r_b_side;
            r_q_side[0] <= n_q0_side;
            for (int k = 0; k < DIV_BITS; k++) begin
                r_q_side[k+1] <= r_q_side[k];
            end
            r_n_side <= r_q_side[DIV_BITS];
            r_m_side <= r_n_side;
            r_f_side <= r_m_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_a_prod[r][c] <= $signed(i_vec[c]) * $signed(i_mat[4*c+r]);
                end
                r_a_tr[r]  <= i_mat[12+r];
                r_b_sum[r] <= 64'(r_a_prod[r][0]) + 64'(r_a_prod[r][1])
                            + 64'(r_a_prod[r][2]);
                r_b_tr[r]  <= r_a_tr[r];
                r_c_o[r]   <= r_b_sum[r][FRAC_BITS+31:FRAC_BITS] + r_b_tr[r];
            end

            r_q_rem[0] <= '0;
            r_q_quo[0] <= '0;
            r_q_den[0] <= w_c[31] ? (~w_c + 32'd1) : w_c;
            r_q_neg[0] <= w_c[31];
            r_q_one[0] <= (w_c == FIX_ONE);
            r_q_o[0]   <= r_c_o[2:0];
            for (int k = 0; k < DIV_BITS; k++) begin
                r_q_rem[k+1] <= n_rem[k];
                r_q_quo[k+1] <= n_quo[k];
                r_q_den[k+1] <= r_q_den[k];
                r_q_neg[k+1] <= r_q_neg[k];
                r_q_one[k+1] <= r_q_one[k];
                r_q_o[k+1]   <= r_q_o[k];
            end

            r_n_inv <= r_q_neg[DIV_BITS] ? (~r_q_quo[DIV_BITS][31:0] + 32'd1)
                                         : r_q_quo[DIV_BITS][31:0];
            r_n_one <= r_q_one[DIV_BITS];
            r_n_o   <= r_q_o[DIV_BITS];

            for (int r = 0; r < 3; r++) begin
                r_m_prod[r] <= $signed(r_n_o[r]) * $signed(r_n_inv);
                r_f_o[r]    <= r_m_one ? r_m_o[r] : r_m_prod[r][FRAC_BITS+31:FRAC_BITS];
            end
            r_m_one <= r_n_one;
            r_m_o   <= r_n_o;
        end
    end

    assign o_side = r_f_side;
    assign o_vec  = r_f_o;

endmodule

FILE: hw/rtl/vertex_project_to_viewport_top.sv
// vertex projection: view and projection transforms, divide and viewport mapping
// throughput: one beat per cycle; each transform's reciprocal divider has one stage per bit
// a stalled output holds the whole pipeline; matrix writes ride along and give no output beat
// reset (synchronous, active low) clears valid bits and viewport registers; matrices are not reset
module vertex_project_to_viewport_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic               i_matrix_pick,
    input  logic [3:0]         i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_vertex_z,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_visible,
    output logic signed [31:0] o_window_x,
    output logic signed [31:0] o_window_y,
    output logic signed [31:0] o_window_depth
);
    import vpv_pkg::*;

    logic        en;
    logic [15:0] r_left, r_bottom;
    logic [14:0] r_span_x, r_span_y;
    t_mat        r_view, r_proj;

    t_side in_side, x1_side, x2_side;
    t_vec3 in_vec, x1_vec, x2_vec;

    t_side              r_v1_side, r_v2_side, r_v3_side;
    logic               r_v1_in, r_v2_in, r_v3_in;
    t_vec3              r_v1_a;
    logic signed [63:0] r_v2_px, r_v2_py;
    logic [31:0]        r_v2_z;
    logic [31:0]        r_v3_x, r_v3_y, r_v3_z;

    logic [31:0] x0, y0, sx, sy, hw, hh;
    logic        in_cube;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        in_side     = '0;
        in_side.vld = i_valid;
        in_side.vtx = (i_command == CMD_PROJECT);
        in_side.pwr = (i_command == CMD_WRITE) && (i_matrix_pick == MAT_PROJ);
        in_side.idx = i_entry_index;
        in_side.val = i_entry_value;
        in_vec      = {i_vertex_z, i_vertex_y, i_vertex_x};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_bottom <= '0;
            r_span_x <= '0;
            r_span_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_BOTTOM: r_bottom <= i_cfg_data;
                CFG_SPAN_X: r_span_x <= i_cfg_data[14:0];
                CFG_SPAN_Y: r_span_y <= i_cfg_data[14:0];
                default:    r_left   <= r_left;
            endcase
        end
    end

    // view writes land on acceptance, projection writes when they reach the second transform
    always_ff @(posedge i_clk) begin
        if (i_valid && en && (i_command == CMD_WRITE) && (i_matrix_pick == MAT_VIEW)) begin
            r_view[i_entry_index] <= i_entry_value;
        end
        if (en && x1_side.vld && x1_side.pwr) begin
            r_proj[x1_side.idx] <= x1_side.val;
        end
    end

    vpv_xform u_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (in_side),
        .i_vec   (in_vec),
        .i_mat   (r_view),
        .o_side  (x1_side),
        .o_vec   (x1_vec)
    );

    vpv_xform u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (x1_side),
        .i_vec   (x1_vec),
        .i_mat   (r_proj),
        .o_side  (x2_side),
        .o_vec   (x2_vec)
    );

    // viewport constants, wrapped to 32 bits
    assign x0 = 32'(signed'(r_left)) << FRAC_BITS;
    assign y0 = 32'(signed'(r_bottom)) << FRAC_BITS;
    assign sx = 32'({17'd0, r_span_x}) << FRAC_BITS;
    assign sy = 32'({17'd0, r_span_y}) << FRAC_BITS;
    assign hw = {sx[31], sx[31:1]};
    assign hh = {sy[31], sy[31:1]};

    always_comb begin
        in_cube = !x2_side.bad;
        for (int r = 0; r < 3; r++) begin
            if (!($signed(x2_vec[r]) > -FIX_ONE && $signed(x2_vec[r]) < FIX_ONE)) begin
                in_cube = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_side <= '0;
            r_v2_side <= '0;
            r_v3_side <= '0;
        end else if (en) begin
            r_v1_side <= x2_side;
            r_v2_side <= r_v1_side;
            r_v3_side <= r_v2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v1_in <= in_cube;
            for (int r = 0; r < 3; r++) begin
                r_v1_a[r] <= x2_vec[r] + FIX_ONE;
            end
            r_v2_in <= r_v1_in;
            r_v2_px <= $signed(hw) * $signed(r_v1_a[0]);
            r_v2_py <= $signed(hh) * $signed(r_v1_a[1]);
            r_v2_z  <= {r_v1_a[2][31], r_v1_a[2][31:1]};
            r_v3_in <= r_v2_in;
            r_v3_x  <= r_v2_in ? x0 + r_v2_px[FRAC_BITS+31:FRAC_BITS] : '0;
            r_v3_y  <= r_v2_in ? y0 + r_v2_py[FRAC_BITS+31:FRAC_BITS] : '0;
            r_v3_z  <= r_v2_in ? r_v2_z : '0;
        end
    end

    assign o_valid        = r_v3_side.vld && r_v3_side.vtx;
    assign o_visible      = r_v3_in;
    assign o_window_x     = r_v3_x;
    assign o_window_y     = r_v3_y;
    assign o_window_depth = r_v3_z;

endmodule

FILE: verif/tb_vertex_project_to_viewport_top.sv
// testbench for the vertex projection pipeline: directed and random beats, scoreboard check
`timescale 1ns / 1ps

module tb_vertex_project_to_viewport_top;
    import vpv_pkg::*;

    localparam int PIPE_LAT  = 4 * FRAC_BITS + 19;
    localparam int N_RANDOM  = 1000;
    localparam int N_PHASES  = 4;
    localparam logic signed [31:0] HALF = 32'sd1 <<< (FRAC_BITS - 1);

    typedef struct {
        logic               visible;
        logic signed [31:0] win_x;
        logic signed [31:0] win_y;
        logic signed [31:0] win_depth;
    } t_window;

    class window_scoreboard;
        logic signed [31:0] mats[2][16];
        logic [15:0]        vp_left, vp_bottom;
        logic [14:0]        vp_span_x, vp_span_y;
        t_window            pending[$];
        int                 errors, projected, shown, writes;

        function new();
            vp_left = 0; vp_bottom = 0; vp_span_x = 0; vp_span_y = 0;
            errors = 0; projected = 0; shown = 0; writes = 0;
            foreach (mats[m, e]) mats[m][e] = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_LEFT:   vp_left   = data;
                CFG_BOTTOM: vp_bottom = data;
                CFG_SPAN_X: vp_span_x = data[14:0];
                default:    vp_span_y = data[14:0];
            endcase
        endfunction

        function logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
            logic signed [63:0] p;
            p = 64'(a) * 64'(b);
            return p[FRAC_BITS +: 32];
        endfunction

        function logic signed [31:0] mat_row(logic signed [31:0] v[3], int m, int r);
            logic signed [63:0] s;
            s = 64'(v[0]) * 64'(mats[m][r]) + 64'(v[1]) * 64'(mats[m][4 + r])
              + 64'(v[2]) * 64'(mats[m][8 + r]);
            return s[FRAC_BITS +: 32] + mats[m][12 + r];
        endfunction

        // one transform with perspective divide; zero when w is zero
        function bit transform(logic signed [31:0] v[3], int m, output logic signed [31:0] o[3]);
            logic signed [31:0] w, inv;
            logic signed [63:0] q;
            for (int r = 0; r < 3; r++) o[r] = mat_row(v, m, r);
            w = mat_row(v, m, 3);
            if (w != FIX_ONE) begin
                if (w == 0) return 0;
                q = (64'sd1 <<< (2 * FRAC_BITS)) / 64'(w);
                inv = q[31:0];
                for (int r = 0; r < 3; r++) o[r] = fx_mul(o[r], inv);
            end
            return 1;
        endfunction

        function void note(logic cmd, logic pick, logic [3:0] idx, logic signed [31:0] val,
                           logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] vz);
            logic signed [31:0] v[3], vv[3], vp[3];
            logic signed [31:0] x0, y0, hw, hh;
            t_window res;
            if (cmd == CMD_WRITE) begin
                mats[pick][idx] = val;
                writes++;
                return;
            end
            v[0] = vx; v[1] = vy; v[2] = vz;
            res = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
            if (transform(v, MAT_VIEW, vv) && transform(vv, MAT_PROJ, vp)) begin
                if (-FIX_ONE < vp[0] && vp[0] < FIX_ONE && -FIX_ONE < vp[1]
                    && vp[1] < FIX_ONE && -FIX_ONE < vp[2] && vp[2] < FIX_ONE) begin
                    x0 = 32'($signed(vp_left)) <<< FRAC_BITS;
                    y0 = 32'($signed(vp_bottom)) <<< FRAC_BITS;
                    hw = fx_mul(32'({17'd0, vp_span_x}) <<< FRAC_BITS, HALF);
                    hh = fx_mul(32'({17'd0, vp_span_y}) <<< FRAC_BITS, HALF);
                    res.visible   = 1'b1;
                    res.win_x     = x0 + fx_mul(hw, vp[0] + FIX_ONE);
                    res.win_y     = y0 + fx_mul(hh, vp[1] + FIX_ONE);
                    res.win_depth = fx_mul(vp[2] + FIX_ONE, HALF);
                    shown++;
                end
            end
            projected++;
            pending.push_back(res);
        endfunction

        function void check(logic vis, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
            t_window e;
            if (pending.size() == 0) begin
                $error("output beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (vis !== e.visible) begin
                $error("visible: expected %0d, got %0d", e.visible, vis); errors++;
            end
            if (x !== e.win_x) begin
                $error("window_x: expected %0d, got %0d", e.win_x, x); errors++;
            end
            if (y !== e.win_y) begin
                $error("window_y: expected %0d, got %0d", e.win_y, y); errors++;
            end
            if (z !== e.win_depth) begin
                $error("window_depth: expected %0d, got %0d", e.win_depth, z); errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic               i_command = 0;
    logic               i_matrix_pick = 0;
    logic [3:0]         i_entry_index = 0;
    logic signed [31:0] i_entry_value = 0;
    logic signed [31:0] i_vertex_x = 0;
    logic signed [31:0] i_vertex_y = 0;
    logic signed [31:0] i_vertex_z = 0;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_index = 0;
    logic [15:0]        i_cfg_data = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic               o_visible;
    logic signed [31:0] o_window_x, o_window_y, o_window_depth;

    window_scoreboard sb = new();
    bit idle_on = 1;
    int stall_left = 0;

    vertex_project_to_viewport_top DUT (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // downstream: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check(o_visible, o_window_x, o_window_y, o_window_depth);
    end

    task automatic send_beat(logic cmd, logic pick, logic [3:0] idx, logic signed [31:0] val,
                             logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_matrix_pick <= pick;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_vertex_x <= vx;
        i_vertex_y <= vy;
        i_vertex_z <= vz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note(cmd, pick, idx, val, vx, vy, vz);
    endtask

    task automatic write_entry(logic pick, int idx, logic signed [31:0] val);
        send_beat(CMD_WRITE, pick, 4'(idx), val, $urandom, $urandom, $urandom);
    endtask

    task automatic project(logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] vz);
        send_beat(CMD_PROJECT, 1'($urandom), 4'($urandom), $urandom, vx, vy, vz);
    endtask

    function automatic logic signed [31:0] near_unit();
        return $signed($urandom_range(0, 2 * FIX_ONE)) - FIX_ONE;
    endfunction

    // kind 0: identity pair; otherwise a random affine view and a perspective-like projection
    task automatic load_matrices(int kind);
        logic signed [31:0] val;
        for (int m = 0; m < 2; m++) begin
            for (int e = 0; e < 16; e++) begin
                val = (e % 5 == 0) ? FIX_ONE : 32'sd0;
                if (kind != 0) begin
                    if (m == MAT_VIEW && e % 4 != 3)
                        val = near_unit() / 2 + ((e % 5 == 0) ? FIX_ONE / 2 : 0);
                    else if (m == MAT_PROJ && e % 5 == 0 && e != 15)
                        val = $signed($urandom_range(FIX_ONE / 4, 2 * FIX_ONE));
                    else if (m == MAT_PROJ && e == 11)
                        val = ($urandom_range(0, 1) != 0) ? -FIX_ONE : near_unit();
                    else if (m == MAT_PROJ && e == 15)
                        val = $signed($urandom_range(0, 2 * FIX_ONE));
                end
                write_entry(1'(m), e, val);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    // write enable stays high across a group of writes; the caller drops it afterwards
    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_viewport(int phase);
        case (phase)
            0: begin
                cfg_write(CFG_LEFT, 16'h8000);   cfg_write(CFG_BOTTOM, 16'h7fff);
                cfg_write(CFG_SPAN_X, 16'hffff); cfg_write(CFG_SPAN_Y, 16'h0000);
            end
            1: begin
                cfg_write(CFG_LEFT, 16'h7fff);   cfg_write(CFG_BOTTOM, 16'h8000);
                cfg_write(CFG_SPAN_X, 16'h0000); cfg_write(CFG_SPAN_Y, 16'h7fff);
            end
            default: begin
                cfg_write(CFG_LEFT, 16'($urandom));  cfg_write(CFG_BOTTOM, 16'($urandom));
                cfg_write(CFG_SPAN_X, 16'($urandom_range(0, 2000)));
                cfg_write(CFG_SPAN_Y, 16'($urandom));
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #200_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(CFG_LEFT, 16'd10);   cfg_write(CFG_BOTTOM, 16'hfff0);
        cfg_write(CFG_SPAN_X, 16'd640); cfg_write(CFG_SPAN_Y, 16'd480);
        i_cfg_we <= 1'b0;

        // directed: identity with w one, edges of the cube, extremes
        load_matrices(0);
        project(0, 0, 0);
        project(FIX_ONE - 1, -FIX_ONE + 1, FIX_ONE - 1);
        project(FIX_ONE, 0, 0);
        project(0, -FIX_ONE, 0);
        project(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        project(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        // w scaled by two in the projection: divide path
        write_entry(MAT_PROJ, 15, 2 * FIX_ONE);
        project(FIX_ONE + FIX_ONE / 2, -FIX_ONE, FIX_ONE / 3);
        // zero w in the projection
        write_entry(MAT_PROJ, 15, 0);
        project(FIX_ONE / 2, FIX_ONE / 2, FIX_ONE / 2);
        // zero w in the view stage
        write_entry(MAT_VIEW, 15, 0);
        project(-FIX_ONE / 2, 0, FIX_ONE / 4);
        write_entry(MAT_VIEW, 15, 32'sh80000000);
        write_entry(MAT_PROJ, 15, 32'sh7fffffff);
        project(FIX_ONE / 8, FIX_ONE / 8, FIX_ONE / 8);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_viewport(ph);
            if (ph == N_PHASES - 1) idle_on = 0;
            for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
                if (n % 150 == 0) load_matrices($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 5))
                        0:       write_entry(1'($urandom), $urandom, $urandom);
                        1:       write_entry(1'($urandom), $urandom,
                                             $urandom_range(0, 1) * FIX_ONE);
                        default: write_entry(1'($urandom), $urandom, near_unit());
                    endcase
                end else if ($urandom_range(0, 4) == 0) begin
                    project($urandom, $urandom, $urandom);
                end else begin
                    project(near_unit(), near_unit(), near_unit());
                end
            end
            drain();
        end

        $display("projected %0d vertices (%0d visible), %0d matrix writes, %0d viewport settings",
                 sb.projected, sb.shown, sb.writes, N_PHASES + 1);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: vertex_project_to_viewport_top.f
hw/rtl/vpv_pkg.sv
hw/rtl/vpv_xform.sv
hw/rtl/vertex_project_to_viewport_top.sv
verif/tb_vertex_project_to_viewport_top.sv
